// ----- design/ctse_pkg.sv -----
// shared types, codes and wrap helpers for the clock time-set editor
package ctse_pkg;

  localparam int KeyWidth    = 3;
  localparam int PeriodWidth = 8;

  localparam logic [7:0] YearMod   = 8'd100;
  localparam logic [7:0] MonthMod  = 8'd12;
  localparam logic [7:0] HourMod   = 8'd24;
  localparam logic [7:0] MinSecMod = 8'd60;
  localparam logic [7:0] DaysShort = 8'd28;
  localparam logic [7:0] DaysMid   = 8'd30;
  localparam logic [7:0] DaysLong  = 8'd31;
  localparam logic [PeriodWidth-1:0] BlinkPeriodReset = 8'd5;

  typedef enum logic [KeyWidth-1:0] {
    KEY_NONE = 3'd0,
    KEY_MODE = 3'd1,
    KEY_OK   = 3'd2,
    KEY_ADD  = 3'd3,
    KEY_SUB  = 3'd4
  } key_t;

  typedef enum logic [2:0] {
    MODE_DISPLAY = 3'd0,
    MODE_YEAR    = 3'd1,
    MODE_MONTH   = 3'd2,
    MODE_DAY     = 3'd3,
    MODE_HOUR    = 3'd4,
    MODE_MINUTE  = 3'd5,
    MODE_SECOND  = 3'd6
  } edit_t;

  typedef struct packed {
    logic  load;
    logic  adjust;
    logic  up;
    edit_t field;
    edit_t mode_next;
  } ctse_cmd_t;

  typedef struct packed {
    logic out_free;
  } ctse_stat_t;

  // reduce v modulo m for v below three times m
  function automatic logic [7:0] wrap_mod(input logic [7:0] v, input logic [7:0] m);
    logic [7:0] m2;
    m2 = m << 1;
    if (v >= m2) begin
      return v - m2;
    end else if (v >= m) begin
      return v - m;
    end else begin
      return v;
    end
  endfunction

  function automatic logic [7:0] month_len(input logic [3:0] month);
    logic [7:0] len;
    case (month)
      4'd2: len = DaysShort;
      4'd4, 4'd6, 4'd9, 4'd11: len = DaysMid;
      default: len = DaysLong;
    endcase
    return len;
  endfunction

endpackage

// ----- design/clock_time_set_editor_top.sv -----
// top level of the clock time-set editor
// The block takes one transaction per clock cycle: the key handling, field
// wrap arithmetic and blink divider are all combinational ahead of one
// output register, and a new input is taken whenever that register is empty
// or its result is taken in the same cycle. Each result shows in the cycle
// after its input is accepted. blink_period may be written at any idle time.
module clock_time_set_editor_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,     // blink_period
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,    // cur_year, cur_month, cur_day, cur_hour,
                                       // cur_minute, cur_second, zero pad
  input  logic [2:0]  s_axis_tuser,    // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,    // mode_out, blink_on, visible_mask, new_year,
                                       // new_month, new_day, new_hour, new_minute,
                                       // new_second, zero pad
  output logic        m_axis_tuser     // write_time
);
  import ctse_pkg::*;

  ctse_cmd_t  cmd;
  ctse_stat_t stat;
  logic [2:0] mode_out;
  logic       blink_on;
  logic [5:0] visible_mask;
  logic [6:0] new_year;
  logic [3:0] new_month;
  logic [4:0] new_day;
  logic [4:0] new_hour;
  logic [5:0] new_minute;
  logic [5:0] new_second;

  ctse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .req_type (s_axis_tuser),
    .stat     (stat),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  ctse_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .cmd          (cmd),
    .stat         (stat),
    .cur_year     (s_axis_tdata[6:0]),
    .cur_month    (s_axis_tdata[10:7]),
    .cur_day      (s_axis_tdata[15:11]),
    .cur_hour     (s_axis_tdata[20:16]),
    .cur_minute   (s_axis_tdata[26:21]),
    .cur_second   (s_axis_tdata[32:27]),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .mode_out     (mode_out),
    .blink_on     (blink_on),
    .visible_mask (visible_mask),
    .write_time   (m_axis_tuser),
    .new_year     (new_year),
    .new_month    (new_month),
    .new_day      (new_day),
    .new_hour     (new_hour),
    .new_minute   (new_minute),
    .new_second   (new_second)
  );

  assign m_axis_tdata = {5'd0, new_second, new_minute, new_hour, new_day, new_month,
                         new_year, visible_mask, blink_on, mode_out};

endmodule

// ----- design/ctse_ctrl.sv -----
// controller: edit-field state machine and input handshake
module ctse_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [2:0]            req_type,
  input  ctse_pkg::ctse_stat_t  stat,
  output logic                  in_ready,
  output ctse_pkg::ctse_cmd_t   cmd
);
  import ctse_pkg::*;

  edit_t state;
  edit_t state_next;
  logic  fire;

  assign fire = in_valid && stat.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MODE_DISPLAY;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    if (fire) begin
      if (req_type == KEY_MODE) begin
        case (state)
          MODE_DISPLAY: state_next = MODE_YEAR;
          MODE_YEAR:    state_next = MODE_MONTH;
          MODE_MONTH:   state_next = MODE_DAY;
          MODE_DAY:     state_next = MODE_HOUR;
          MODE_HOUR:    state_next = MODE_MINUTE;
          MODE_MINUTE:  state_next = MODE_SECOND;
          default:      state_next = MODE_YEAR;
        endcase
      end else if (req_type == KEY_OK) begin
        state_next = MODE_DISPLAY;
      end
    end
  end

  always_comb begin
    in_ready      = stat.out_free;
    cmd.load      = fire;
    cmd.adjust    = fire && (req_type == KEY_ADD || req_type == KEY_SUB)
                    && state != MODE_DISPLAY;
    cmd.up        = req_type == KEY_ADD;
    cmd.field     = state;
    cmd.mode_next = state_next;
  end

`ifndef ASSERT_OFF
  a_reset_display: assert property (@(posedge clk) rst |=> state == MODE_DISPLAY)
    else $error("edit field not cleared by reset");
  a_mode_wrap: assert property (@(posedge clk) disable iff (rst)
      fire && req_type == KEY_MODE && state == MODE_SECOND |=> state == MODE_YEAR)
    else $error("mode key did not wrap to year");
  a_ok_display: assert property (@(posedge clk) disable iff (rst)
      fire && req_type == KEY_OK |=> state == MODE_DISPLAY)
    else $error("ok key did not return to display");
  a_adjust_editing: assert property (@(posedge clk) disable iff (rst)
      cmd.adjust |-> cmd.load && state != MODE_DISPLAY)
    else $error("adjust issued outside edit mode");
`endif

endmodule

// ----- design/ctse_dp.sv -----
// datapath: field wrap arithmetic, blink divider and output register
module ctse_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data,
  input  ctse_pkg::ctse_cmd_t  cmd,
  output ctse_pkg::ctse_stat_t stat,
  input  logic [6:0]           cur_year,
  input  logic [3:0]           cur_month,
  input  logic [4:0]           cur_day,
  input  logic [4:0]           cur_hour,
  input  logic [5:0]           cur_minute,
  input  logic [5:0]           cur_second,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           mode_out,
  output logic                 blink_on,
  output logic [5:0]           visible_mask,
  output logic                 write_time,
  output logic [6:0]           new_year,
  output logic [3:0]           new_month,
  output logic [4:0]           new_day,
  output logic [4:0]           new_hour,
  output logic [5:0]           new_minute,
  output logic [5:0]           new_second
);
  import ctse_pkg::*;

  logic [PeriodWidth-1:0] blink_period;
  logic [PeriodWidth-1:0] blink_count;
  logic [PeriodWidth-1:0] blink_count_next;
  logic [PeriodWidth-1:0] cnt_inc;
  logic                   blink_state;
  logic                   blink_state_next;
  logic [5:0]             mask_next;
  logic [2:0]             bit_idx;
  logic [7:0]             len;
  logic [6:0]             year_next;
  logic [3:0]             month_next;
  logic [4:0]             day_next;
  logic [4:0]             hour_next;
  logic [5:0]             minute_next;
  logic [5:0]             second_next;
  logic [7:0]             y8, mo8, d8, h8, mi8, s8;

  assign stat.out_free = !out_valid || out_ready;

  assign y8  = {1'b0, cur_year};
  assign mo8 = {4'd0, cur_month};
  assign d8  = {3'd0, cur_day};
  assign h8  = {3'd0, cur_hour};
  assign mi8 = {2'd0, cur_minute};
  assign s8  = {2'd0, cur_second};
  assign len = month_len(cur_month);

  always_comb begin
    year_next   = cur_year;
    month_next  = cur_month;
    day_next    = cur_day;
    hour_next   = cur_hour;
    minute_next = cur_minute;
    second_next = cur_second;
    if (cmd.adjust) begin
      case (cmd.field)
        MODE_YEAR: year_next = 7'(wrap_mod(cmd.up ? y8 + 8'd1 : y8 + YearMod - 8'd1,
                                           YearMod));
        MODE_MONTH: month_next = 4'(wrap_mod(cmd.up ? mo8 : mo8 + MonthMod - 8'd2,
                                             MonthMod) + 8'd1);
        MODE_DAY: day_next = 5'(wrap_mod(cmd.up ? d8 : d8 + len - 8'd2, len) + 8'd1);
        MODE_HOUR: hour_next = 5'(wrap_mod(cmd.up ? h8 + 8'd1 : h8 + HourMod - 8'd1,
                                           HourMod));
        MODE_MINUTE: minute_next = 6'(wrap_mod(cmd.up ? mi8 + 8'd1
                                                      : mi8 + MinSecMod - 8'd1, MinSecMod));
        MODE_SECOND: second_next = 6'(wrap_mod(cmd.up ? s8 + 8'd1
                                                      : s8 + MinSecMod - 8'd1, MinSecMod));
        default: ;
      endcase
    end
  end

  always_comb begin
    cnt_inc          = blink_count + 8'd1;
    blink_count_next = cnt_inc;
    blink_state_next = blink_state;
    if (cnt_inc >= blink_period) begin
      blink_count_next = '0;
      blink_state_next = !blink_state;
    end
  end

  always_comb begin
    bit_idx   = 3'(cmd.mode_next) - 3'd1;
    mask_next = 6'h3F;
    if (cmd.mode_next != MODE_DISPLAY && !blink_state_next) begin
      mask_next[bit_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_period <= BlinkPeriodReset;
      blink_count  <= '0;
      blink_state  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        blink_period <= cfg_wr_data;
      end
      if (cmd.load) begin
        blink_count <= blink_count_next;
        blink_state <= blink_state_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_out     <= 3'(cmd.mode_next);
      blink_on     <= blink_state_next;
      visible_mask <= mask_next;
      write_time   <= cmd.adjust;
      new_year     <= year_next;
      new_month    <= month_next;
      new_day      <= day_next;
      new_hour     <= hour_next;
      new_minute   <= minute_next;
      new_second   <= second_next;
    end
  end

`ifndef ASSERT_OFF
  a_blink_on_load: assert property (@(posedge clk) disable iff (rst)
      !cmd.load |=> $stable(blink_state) && $stable(blink_count))
    else $error("blink divider moved without a transaction");
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
      cmd.load |=> out_valid)
    else $error("loaded result not presented");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
      cmd.load |-> stat.out_free)
    else $error("load into occupied output register");
`endif

endmodule

// ----- bench/clock_time_set_editor_top_test.sv -----
// self-checking stream testbench for the clock time-set editor
module clock_time_set_editor_top_test;
  import ctse_pkg::*;

  localparam int IdleLimit   = 2000;
  localparam int DrainCycles = 4;
  localparam int KeyCodeMax  = 7;
  localparam int PhaseCount  = 6;
  localparam int PhaseItems  = 178;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } clock_fields_t;

  typedef struct {
    logic [2:0]    key;
    clock_fields_t now;
  } key_event_t;

  typedef struct {
    edit_t         mode;
    logic          blink;
    logic [5:0]    mask;
    logic          write;
    clock_fields_t adjusted;
  } clock_view_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;

  key_event_t  key_queue[$];
  clock_view_t expected_views[$];

  edit_t      edit_sel;
  logic [7:0] blink_cnt;
  logic       blink_shown;
  logic [7:0] blink_period_cfg;

  bit in_fire;
  bit out_fire;
  bit in_idle_on;
  bit out_idle_on;
  int in_gap;
  int out_stall;
  int idle_cycles;
  int fails;

  clock_time_set_editor_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int days_in(input logic [3:0] month);
    case (month)
      4'd2: return 28;
      4'd4, 4'd6, 4'd9, 4'd11: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic int step_wrap(input int v, input int m, input bit up);
    return up ? (v + 1) % m : (v + m - 1) % m;
  endfunction

  // one pass of the editor: key, then blink divider, then display mask
  function automatic clock_view_t advance_editor(input logic [2:0] key,
                                                 input clock_fields_t t);
    clock_view_t v;
    bit          up;
    int          len;
    v.write    = 1'b0;
    v.adjusted = t;
    up         = (key == KEY_ADD);
    if (key == KEY_MODE) begin
      edit_sel = (edit_sel == MODE_SECOND) ? MODE_YEAR : edit_t'(edit_sel + 1);
    end else if (key == KEY_OK) begin
      edit_sel = MODE_DISPLAY;
    end else if ((key == KEY_ADD || key == KEY_SUB) && edit_sel != MODE_DISPLAY) begin
      v.write = 1'b1;
      case (edit_sel)
        MODE_YEAR: v.adjusted.year = 7'(step_wrap(t.year, 100, up));
        MODE_MONTH: v.adjusted.month = 4'(step_wrap(t.month + 11, 12, up) + 1);
        MODE_DAY: begin
          len = days_in(t.month);
          v.adjusted.day = 5'(up ? (t.day % len) + 1 : (t.day + len - 2) % len + 1);
        end
        MODE_HOUR: v.adjusted.hour = 5'(step_wrap(t.hour, 24, up));
        MODE_MINUTE: v.adjusted.minute = 6'(step_wrap(t.minute, 60, up));
        default: v.adjusted.second = 6'(step_wrap(t.second, 60, up));
      endcase
    end
    blink_cnt = blink_cnt + 8'd1;
    if (blink_cnt >= blink_period_cfg) begin
      blink_cnt   = 8'd0;
      blink_shown = ~blink_shown;
    end
    v.mode  = edit_sel;
    v.blink = blink_shown;
    v.mask  = 6'h3f;
    if (edit_sel != MODE_DISPLAY && !blink_shown) begin
      v.mask[edit_sel - 1] = 1'b0;
    end
    return v;
  endfunction

  function automatic clock_fields_t fields_from_bus(input logic [39:0] d);
    clock_fields_t f;
    f.year   = d[6:0];
    f.month  = d[10:7];
    f.day    = d[15:11];
    f.hour   = d[20:16];
    f.minute = d[26:21];
    f.second = d[32:27];
    return f;
  endfunction

  function automatic clock_view_t view_from_bus(input logic [47:0] d, input logic wr);
    clock_view_t v;
    v.mode            = edit_t'(d[2:0]);
    v.blink           = d[3];
    v.mask            = d[9:4];
    v.write           = wr;
    v.adjusted.year   = d[16:10];
    v.adjusted.month  = d[20:17];
    v.adjusted.day    = d[25:21];
    v.adjusted.hour   = d[30:26];
    v.adjusted.minute = d[36:31];
    v.adjusted.second = d[42:37];
    return v;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endtask

  function automatic int draw_idle(input bit on);
    int r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // predictor and scoreboard on the rising edge
  always @(posedge clk) begin : monitor
    clock_view_t got;
    clock_view_t want;
    if (rst) begin
      edit_sel         = MODE_DISPLAY;
      blink_cnt        = 8'd0;
      blink_shown      = 1'b0;
      blink_period_cfg = BlinkPeriodReset;
      in_fire          = 1'b0;
      out_fire         = 1'b0;
      idle_cycles      = 0;
    end else begin
      if (cfg_wr_en) begin
        blink_period_cfg = cfg_wr_data;
      end
      in_fire  = s_axis_tvalid && s_axis_tready;
      out_fire = m_axis_tvalid && m_axis_tready;
      if (in_fire) begin
        expected_views.push_back(advance_editor(s_axis_tuser, fields_from_bus(s_axis_tdata)));
      end
      if (out_fire) begin
        got = view_from_bus(m_axis_tdata, m_axis_tuser);
        if (expected_views.size() == 0) begin
          $error("result transaction with no expected value");
          fails++;
        end else begin
          want = expected_views.pop_front();
          check_field("mode_out", want.mode, got.mode);
          check_field("blink_on", want.blink, got.blink);
          check_field("visible_mask", want.mask, got.mask);
          check_field("write_time", want.write, got.write);
          check_field("new_year", want.adjusted.year, got.adjusted.year);
          check_field("new_month", want.adjusted.month, got.adjusted.month);
          check_field("new_day", want.adjusted.day, got.adjusted.day);
          check_field("new_hour", want.adjusted.hour, got.adjusted.hour);
          check_field("new_minute", want.adjusted.minute, got.adjusted.minute);
          check_field("new_second", want.adjusted.second, got.adjusted.second);
        end
      end
      if (!in_fire && !out_fire &&
          (key_queue.size() > 0 || s_axis_tvalid || expected_views.size() > 0)) begin
        idle_cycles++;
      end else begin
        idle_cycles = 0;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // stimulus and backpressure on the falling edge
  always @(negedge clk) begin : driver
    key_event_t ev;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (!s_axis_tvalid || in_fire) begin
        if (in_gap > 0) begin
          s_axis_tvalid <= 1'b0;
          in_gap--;
        end else if (key_queue.size() > 0) begin
          ev = key_queue.pop_front();
          s_axis_tuser  <= ev.key;
          s_axis_tdata  <= {7'd0, ev.now.second, ev.now.minute, ev.now.hour,
                            ev.now.day, ev.now.month, ev.now.year};
          s_axis_tvalid <= 1'b1;
          in_gap = draw_idle(in_idle_on);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      if (out_stall > 0) begin
        m_axis_tready <= 1'b0;
        out_stall--;
      end else begin
        m_axis_tready <= 1'b1;
        out_stall = draw_idle(out_idle_on);
      end
    end
  end

  function automatic clock_fields_t at(input int y, input int mo, input int d,
                                       input int h, input int mi, input int s);
    clock_fields_t f;
    f.year   = 7'(y);
    f.month  = 4'(mo);
    f.day    = 5'(d);
    f.hour   = 5'(h);
    f.minute = 6'(mi);
    f.second = 6'(s);
    return f;
  endfunction

  function automatic clock_fields_t any_time();
    return clock_fields_t'({1'($urandom()), $urandom()});
  endfunction

  function automatic clock_fields_t sane_time();
    clock_fields_t f;
    f.year   = 7'($urandom_range(0, 99));
    f.month  = 4'($urandom_range(1, 12));
    f.day    = 5'($urandom_range(1, days_in(f.month)));
    f.hour   = 5'($urandom_range(0, 23));
    f.minute = 6'($urandom_range(0, 59));
    f.second = 6'($urandom_range(0, 59));
    return f;
  endfunction

  task automatic queue_key(input logic [2:0] key, input clock_fields_t t);
    key_event_t ev;
    ev.key = key;
    ev.now = t;
    key_queue.push_back(ev);
  endtask

  task automatic wait_idle();
    while (key_queue.size() > 0 || s_axis_tvalid || expected_views.size() > 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic program_period(input logic [7:0] period);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= period;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // mostly edit sessions: return to display, enter a field, adjust it; the rest is noise
  task automatic queue_random(input int count);
    int queued;
    int n;
    int r;
    logic [2:0] key;
    queued = 0;
    while (queued < count) begin
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 8);
        repeat (n) queue_key(3'($urandom_range(0, KeyCodeMax)), any_time());
        queued += n;
      end else begin
        queue_key(KEY_OK, sane_time());
        n = $urandom_range(1, 8);
        repeat (n) queue_key(KEY_MODE, sane_time());
        queued += n + 1;
        n = $urandom_range(1, 12);
        repeat (n) begin
          r = $urandom_range(0, 9);
          key = (r < 4) ? KEY_ADD : (r < 8) ? KEY_SUB : KEY_NONE;
          queue_key(key, ($urandom_range(0, 4) == 0) ? any_time() : sane_time());
        end
        queued += n;
      end
    end
  endtask

  initial begin : sequencer
    logic [7:0] period_plan[PhaseCount];
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = 8'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 40'd0;
    s_axis_tuser  = KEY_NONE;
    m_axis_tready = 1'b0;
    in_idle_on    = 1'b1;
    out_idle_on   = 1'b1;
    in_gap        = 0;
    out_stall     = 0;
    fails         = 0;
    period_plan   = '{8'd1, 8'd255, 8'd3, 8'($urandom_range(2, 254)), 8'd2, 8'd5};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed pass at the reset blink period
    queue_key(KEY_NONE, at(0, 0, 0, 0, 0, 0));
    queue_key(KEY_NONE, at(127, 15, 31, 31, 63, 63));
    queue_key(KEY_ADD, at(50, 6, 15, 12, 30, 30));
    queue_key(KEY_OK, at(50, 6, 15, 12, 30, 30));
    for (int k = KEY_SUB + 1; k <= KeyCodeMax; k++) begin
      queue_key(3'(k), at(10, 3, 3, 3, 3, 3));
    end
    queue_key(KEY_MODE, at(99, 1, 1, 0, 0, 0));
    queue_key(KEY_ADD, at(99, 1, 1, 0, 0, 0));
    queue_key(KEY_SUB, at(0, 1, 1, 0, 0, 0));
    queue_key(KEY_MODE, at(20, 12, 1, 0, 0, 0));
    queue_key(KEY_ADD, at(20, 12, 1, 0, 0, 0));
    queue_key(KEY_SUB, at(20, 1, 1, 0, 0, 0));
    queue_key(KEY_SUB, at(20, 15, 1, 0, 0, 0));
    queue_key(KEY_MODE, at(20, 2, 28, 0, 0, 0));
    queue_key(KEY_ADD, at(20, 2, 28, 0, 0, 0));
    queue_key(KEY_SUB, at(20, 4, 1, 0, 0, 0));
    queue_key(KEY_ADD, at(20, 0, 31, 0, 0, 0));
    queue_key(KEY_SUB, at(20, 13, 0, 0, 0, 0));
    queue_key(KEY_MODE, at(20, 5, 5, 23, 0, 0));
    queue_key(KEY_ADD, at(20, 5, 5, 23, 0, 0));
    queue_key(KEY_SUB, at(20, 5, 5, 0, 0, 0));
    queue_key(KEY_MODE, at(20, 5, 5, 5, 59, 0));
    queue_key(KEY_ADD, at(20, 5, 5, 5, 59, 0));
    queue_key(KEY_MODE, at(20, 5, 5, 5, 5, 0));
    queue_key(KEY_SUB, at(20, 5, 5, 5, 5, 0));
    queue_key(KEY_MODE, at(20, 5, 5, 5, 5, 5));
    queue_key(KEY_OK, at(20, 5, 5, 5, 5, 5));
    wait_idle();

    for (int p = 0; p < PhaseCount; p++) begin
      program_period(period_plan[p]);
      in_idle_on  = (p != 2);
      out_idle_on = (p != 2) && (p != 4);
      queue_random(PhaseItems);
      wait_idle();
    end

    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/ctse_pkg.sv
design/ctse_ctrl.sv
design/ctse_dp.sv
design/clock_time_set_editor_top.sv
bench/clock_time_set_editor_top_test.sv
